@@ design/uudts_pkg.sv @@
package uudts_pkg;

  // position counter inside a line; covers the deepest group read (index 84)
  localparam int IDX_W = 7;

  localparam logic [7:0] CHAR_NL   = 8'd10;
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_BIAS = 8'd32;

  localparam logic [IDX_W-1:0] BEGIN_LEN = 7'd5;
  localparam logic [IDX_W-1:0] END_LEN   = 7'd3;
  localparam logic [IDX_W-1:0] M_LEN_A   = 7'd62;
  localparam logic [IDX_W-1:0] M_LEN_B   = 7'd63;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_END   = 2'd2,
    KIND_SHORT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
  } res_t;

  typedef struct packed {
    logic issue;
    logic in_range;
  } rd_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BCHK,
    ST_BSHORT,
    ST_BEGIN,
    ST_MCHK,
    ST_DSTART,
    ST_CNT,
    ST_GRP,
    ST_EMIT,
    ST_DDONE,
    ST_ECHK,
    ST_P1CHK,
    ST_EEND,
    ST_CLEAN,
    ST_LSHORT,
    ST_FLUSH
  } st_t;

  typedef enum logic [1:0] {
    PH_CUR,
    PH_PREV2,
    PH_PREV1
  } phase_t;

  function automatic logic [7:0] begin_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h67;  // g
      3'd3:    c = 8'h69;  // i
      3'd4:    c = 8'h6E;  // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] end_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0:    c = 8'h65;  // e
      2'd1:    c = 8'h6E;  // n
      2'd2:    c = 8'h64;  // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ring of three line slots
  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

endpackage

@@ design/uudts_line_mem.sv @@
module uudts_line_mem #(
  parameter int DEPTH  = 240,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/uudts_sextet_unit.sv @@
module uudts_sextet_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  uudts_pkg::rd_req_t req,
  input  logic [7:0]        rd_data,
  output logic [5:0]        sextet,
  output logic [23:0]       acc
);

  logic        issue_d_r;
  logic        in_range_d_r;
  logic [23:0] acc_r;
  logic [7:0]  diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r <= 1'b0;
    end else begin
      issue_d_r <= req.issue;
    end
  end

  always_ff @(posedge clk) begin
    in_range_d_r <= req.in_range;
    if (issue_d_r) begin
      acc_r <= {acc_r[17:0], sextet};
    end
  end

  // characters past the line end read as zero
  assign diff   = rd_data - uudts_pkg::CHAR_BIAS;
  assign sextet = in_range_d_r ? diff[5:0] : 6'd0;
  assign acc    = acc_r;

endmodule

@@ design/uudts_out_stage.sv @@
module uudts_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              emit_valid,
  input  uudts_pkg::res_t   emit,
  output logic              emit_ready,
  input  logic              flush,
  output logic              hold_empty,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  // newest result waits in hold until the next one shows whether it is the last
  logic            hold_v_r;
  uudts_pkg::res_t hold_r;
  logic            out_v_r;
  uudts_pkg::res_t out_r;
  logic            out_last_r;
  logic            out_free;

  assign out_free   = !out_v_r || out_tready;
  assign emit_ready = !hold_v_r || out_free;
  assign hold_empty = !hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (emit_valid && emit_ready) begin
        hold_v_r <= 1'b1;
        if (hold_v_r) begin
          out_v_r <= 1'b1;
        end else if (out_tready) begin
          out_v_r <= 1'b0;
        end
      end else if (flush && hold_v_r && out_free) begin
        hold_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      hold_r <= emit;
      if (hold_v_r) begin
        out_r      <= hold_r;
        out_last_r <= 1'b0;
      end
    end else if (flush && hold_v_r && out_free) begin
      out_r      <= hold_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_r.byte_count, out_r.byte_third, out_r.byte_second,
                       out_r.byte_first};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_r.kind;

endmodule

@@ design/uudecode_text_stream.sv @@
// uudecode over a character stream. Each transfer on the input carries one
// text character (tlast marks the last character of the whole stream). A
// character that does not end a line is stored without leaving idle. A line
// end (newline, LINE_MAX-1 characters, or stream end) starts the line
// sequencer, which holds in_tready low until every result of that character
// has been handed to the output register: checks for begin, data and end
// marks, decoding of each line due (count character, then one read per
// character of each three-byte group, then the emit), slot cleanup and a
// flush, all stretched by output stalls. Group decoding is bound by the
// single read port of the line memory, which feeds one character a cycle
// into the shared sextet unit. Results leave as kind (tuser), up to
// three bytes with their count (tdata) and tlast on the last result caused
// by one input character. The line memory has no reset and no clearing pass.
module uudecode_text_stream #(
  parameter int LINE_MAX = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] byte_first, [15:8] byte_second,
                                  // [23:16] byte_third, [25:24] byte_count
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // [1:0] kind
);

  localparam int LEN_W  = $clog2(LINE_MAX);
  localparam int DEPTH  = 3 * LINE_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = uudts_pkg::IDX_W;

  uudts_pkg::st_t    state_r, state_nxt;
  uudts_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        newest_r, newest_nxt;
  logic              file_open_r, file_open_nxt;
  logic [LEN_W-1:0]  len_r [3];
  logic [LEN_W-1:0]  len_nxt [3];
  logic [2:0]        dec_r, dec_nxt;
  logic [1:0]        cur_r, cur_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic              last_r, last_nxt;
  logic              mb_r, mb_nxt;
  logic              me_r, me_nxt;
  logic              mm_r, mm_nxt;
  logic [LEN_W-1:0]  dlen_r, dlen_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [5:0]        n_r, n_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  uudts_pkg::rd_req_t rd_req;
  logic [5:0]        sextet;
  logic [23:0]       acc;

  logic              emit_valid;
  uudts_pkg::res_t   emit;
  logic              emit_ready;
  logic              flush;
  logic              hold_empty;

  logic [1:0]        s;
  logic [LEN_W-1:0]  len_s;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  len_new;
  logic              eol;
  logic [1:0]        p2;
  logic [1:0]        p1;
  logic [1:0]        dslot;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cur_len_x;
  logic [1:0]        grp_cnt;
  logic [5:0]        n_left;

  function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] sl);
    logic [ADDR_W-1:0] b;
    unique case (sl)
      2'd1:    b = ADDR_W'(LINE_MAX);
      2'd2:    b = ADDR_W'(2 * LINE_MAX);
      default: b = '0;
    endcase
    return b;
  endfunction

  assign s         = (newest_r == 2'd3) ? 2'd0 : newest_r;
  assign len_s     = len_r[s];
  assign len_eff   = (len_s >= LEN_W'(LINE_MAX - 1)) ? LEN_W'(LINE_MAX - 2) : len_s;
  assign len_new   = len_eff + 1'b1;
  assign eol       = (in_tdata == uudts_pkg::CHAR_NL) ||
                     (len_new >= LEN_W'(LINE_MAX - 1)) || in_tlast;
  assign p2        = uudts_pkg::slot_inc(cur_r);
  assign p1        = uudts_pkg::slot_inc(p2);
  assign idx       = pos_r + IDX_W'(k_r);
  assign cur_len_x = IDX_W'(cur_len_r);
  assign grp_cnt   = (n_r >= 6'd3) ? 2'd3 : n_r[1:0];
  assign n_left    = n_r - {4'd0, grp_cnt};
  assign in_tready = (state_r == uudts_pkg::ST_IDLE);
  assign waddr     = slot_base(s) + ADDR_W'(len_eff);

  always_comb begin
    unique case (phase_r)
      uudts_pkg::PH_PREV2: dslot = p2;
      uudts_pkg::PH_PREV1: dslot = p1;
      default:             dslot = cur_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    newest_nxt    = newest_r;
    file_open_nxt = file_open_r;
    len_nxt       = len_r;
    dec_nxt       = dec_r;
    cur_nxt       = cur_r;
    cur_len_nxt   = cur_len_r;
    last_nxt      = last_r;
    mb_nxt        = mb_r;
    me_nxt        = me_r;
    mm_nxt        = mm_r;
    dlen_nxt      = dlen_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    we            = 1'b0;
    raddr         = slot_base(dslot);
    rd_req        = '0;
    emit_valid    = 1'b0;
    emit          = '{kind: uudts_pkg::KIND_DATA, byte_first: 8'd0, byte_second: 8'd0,
                      byte_third: 8'd0, byte_count: 2'd0};
    flush         = 1'b0;

    unique case (state_r)
      uudts_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          we          = 1'b1;
          len_nxt[s]  = len_new;
          newest_nxt  = s;
          cur_nxt     = s;
          cur_len_nxt = len_new;
          last_nxt    = in_tlast;
          // prefix match tracked as characters arrive
          if (IDX_W'(len_eff) < uudts_pkg::BEGIN_LEN) begin
            mb_nxt = ((len_eff == '0) || mb_r) &&
                     (in_tdata == uudts_pkg::begin_char(len_eff[2:0]));
          end
          if (IDX_W'(len_eff) < uudts_pkg::END_LEN) begin
            me_nxt = ((len_eff == '0) || me_r) &&
                     (in_tdata == uudts_pkg::end_char(len_eff[1:0]));
          end
          if (len_eff == '0) begin
            mm_nxt = (in_tdata == uudts_pkg::CHAR_M);
          end
          if (eol) begin
            state_nxt = uudts_pkg::ST_BCHK;
          end
        end
      end
      uudts_pkg::ST_BCHK: begin
        if (mb_r && (cur_len_x >= uudts_pkg::BEGIN_LEN)) begin
          state_nxt = file_open_r ? uudts_pkg::ST_BSHORT : uudts_pkg::ST_BEGIN;
        end else begin
          state_nxt = uudts_pkg::ST_MCHK;
        end
      end
      uudts_pkg::ST_BSHORT: begin
        emit_valid = 1'b1;
        emit.kind  = uudts_pkg::KIND_SHORT;
        if (emit_ready) begin
          file_open_nxt = 1'b0;
          state_nxt     = uudts_pkg::ST_BEGIN;
        end
      end
      uudts_pkg::ST_BEGIN: begin
        emit_valid = 1'b1;
        emit.kind  = uudts_pkg::KIND_BEGIN;
        if (emit_ready) begin
          file_open_nxt = 1'b1;
          state_nxt     = uudts_pkg::ST_MCHK;
        end
      end
      uudts_pkg::ST_MCHK: begin
        if (file_open_r && mm_r && !dec_r[cur_r] &&
            ((cur_len_x == uudts_pkg::M_LEN_A) || (cur_len_x == uudts_pkg::M_LEN_B))) begin
          phase_nxt = uudts_pkg::PH_CUR;
          state_nxt = uudts_pkg::ST_DSTART;
        end else begin
          state_nxt = uudts_pkg::ST_ECHK;
        end
      end
      uudts_pkg::ST_DSTART: begin
        // fetch the count character
        dlen_nxt        = len_r[dslot];
        rd_req.issue    = 1'b1;
        rd_req.in_range = (len_r[dslot] != '0);
        pos_nxt         = IDX_W'(1);
        state_nxt       = uudts_pkg::ST_CNT;
      end
      uudts_pkg::ST_CNT: begin
        n_nxt = sextet;
        k_nxt = 3'd0;
        state_nxt = (sextet == 6'd0) ? uudts_pkg::ST_DDONE : uudts_pkg::ST_GRP;
      end
      uudts_pkg::ST_GRP: begin
        // four reads issued, the last one lands while k is 4
        if (k_r != 3'd4) begin
          rd_req.issue    = 1'b1;
          rd_req.in_range = (idx < IDX_W'(dlen_r));
          if (rd_req.in_range) begin
            raddr = slot_base(dslot) + ADDR_W'(idx);
          end
          k_nxt = k_r + 3'd1;
        end else begin
          state_nxt = uudts_pkg::ST_EMIT;
        end
      end
      uudts_pkg::ST_EMIT: begin
        emit_valid       = 1'b1;
        emit.kind        = uudts_pkg::KIND_DATA;
        emit.byte_first  = {acc[23:18], acc[17:16]};
        emit.byte_second = (grp_cnt >= 2'd2) ? {acc[15:12], acc[11:8]} : 8'd0;
        emit.byte_third  = (grp_cnt == 2'd3) ? {acc[7:6], acc[5:0]} : 8'd0;
        emit.byte_count  = grp_cnt;
        if (emit_ready) begin
          n_nxt     = n_left;
          pos_nxt   = pos_r + IDX_W'(4);
          k_nxt     = 3'd0;
          state_nxt = (n_left == 6'd0) ? uudts_pkg::ST_DDONE : uudts_pkg::ST_GRP;
        end
      end
      uudts_pkg::ST_DDONE: begin
        dec_nxt[dslot] = 1'b1;
        unique case (phase_r)
          uudts_pkg::PH_PREV2: state_nxt = uudts_pkg::ST_P1CHK;
          uudts_pkg::PH_PREV1: state_nxt = uudts_pkg::ST_EEND;
          default:             state_nxt = uudts_pkg::ST_ECHK;
        endcase
      end
      uudts_pkg::ST_ECHK: begin
        if (file_open_r && me_r && (cur_len_x >= uudts_pkg::END_LEN)) begin
          if (!dec_r[p2]) begin
            phase_nxt = uudts_pkg::PH_PREV2;
            state_nxt = uudts_pkg::ST_DSTART;
          end else begin
            state_nxt = uudts_pkg::ST_P1CHK;
          end
        end else begin
          state_nxt = uudts_pkg::ST_CLEAN;
        end
      end
      uudts_pkg::ST_P1CHK: begin
        if (!dec_r[p1]) begin
          phase_nxt = uudts_pkg::PH_PREV1;
          state_nxt = uudts_pkg::ST_DSTART;
        end else begin
          state_nxt = uudts_pkg::ST_EEND;
        end
      end
      uudts_pkg::ST_EEND: begin
        emit_valid = 1'b1;
        emit.kind  = uudts_pkg::KIND_END;
        if (emit_ready) begin
          file_open_nxt = 1'b0;
          state_nxt     = uudts_pkg::ST_CLEAN;
        end
      end
      uudts_pkg::ST_CLEAN: begin
        // oldest slot becomes the line being collected
        len_nxt[p2] = '0;
        dec_nxt[p2] = 1'b0;
        newest_nxt  = p2;
        state_nxt   = (last_r && file_open_r) ? uudts_pkg::ST_LSHORT : uudts_pkg::ST_FLUSH;
      end
      uudts_pkg::ST_LSHORT: begin
        emit_valid = 1'b1;
        emit.kind  = uudts_pkg::KIND_SHORT;
        if (emit_ready) begin
          file_open_nxt = 1'b0;
          state_nxt     = uudts_pkg::ST_FLUSH;
        end
      end
      uudts_pkg::ST_FLUSH: begin
        flush = 1'b1;
        if (hold_empty) begin
          state_nxt = uudts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = uudts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uudts_pkg::ST_IDLE;
      phase_r     <= uudts_pkg::PH_CUR;
      newest_r    <= 2'd0;
      file_open_r <= 1'b0;
      len_r       <= '{default: '0};
      dec_r       <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      newest_r    <= newest_nxt;
      file_open_r <= file_open_nxt;
      len_r       <= len_nxt;
      dec_r       <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cur_len_r <= cur_len_nxt;
    last_r    <= last_nxt;
    mb_r      <= mb_nxt;
    me_r      <= me_nxt;
    mm_r      <= mm_nxt;
    dlen_r    <= dlen_nxt;
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
  end

  uudts_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_tdata),
    .re    (rd_req.issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  uudts_sextet_unit u_sext (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rd_req),
    .rd_data (rdata),
    .sextet  (sextet),
    .acc     (acc)
  );

  uudts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_ready (emit_ready),
    .flush      (flush),
    .hold_empty (hold_empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
